// File: sv/bvc_pkg.sv
// ----------------------------------------------------------------------------
// bvc_pkg: shared types and constants for the battery undervoltage cutoff
// Payload types, request codes, register map and fixed-point scaling constants.
// ----------------------------------------------------------------------------
package bvc_pkg;

    // group size and alarm length
    localparam int unsigned SAMPLES_PER_AVERAGE = 250;
    localparam int unsigned BEEP_LIMIT          = 16;

    // field and state widths
    localparam int unsigned SAMPLE_W    = 10;
    localparam int unsigned SUM_W       = 18;
    localparam int unsigned COUNT_W     = 8;
    localparam int unsigned VOLT_W      = 12;
    localparam int unsigned THRESHOLD_W = 11;
    localparam int unsigned BEEP_W      = 5;

    // converter full scale: 5 V * 6 divider * 100 -> 10 mV units over 1024 codes
    localparam int unsigned FULL_SCALE_NUM = 5 * 6 * 100;
    localparam int unsigned FULL_SCALE_DEN = 1024;

    // voltage = floor(sum * NUM / (DEN * N)), done as a multiply by a rounded-up
    // reciprocal; the shift is wide enough for the result to be exact over the sum range
    localparam logic [63:0] VOLT_DEN =
        64'(FULL_SCALE_DEN) * 64'(SAMPLES_PER_AVERAGE);
    localparam int unsigned VOLT_SHIFT = SUM_W + $clog2(VOLT_DEN + 64'd1);
    localparam logic [63:0] VOLT_MUL =
        ((64'd1 << VOLT_SHIFT) * 64'(FULL_SCALE_NUM) + VOLT_DEN - 64'd1) / VOLT_DEN;
    localparam int unsigned PROD_W = VOLT_SHIFT + VOLT_W;

    // configuration port
    localparam int unsigned PADDR_W = 2;
    localparam int unsigned PDATA_W = 32;
    localparam logic [PADDR_W-1:0] REG_THRESHOLD_ADDR = 2'd0;
    localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 11'd1070;

    typedef enum logic
    {
        REQ_SAMPLE = 1'b0,
        REQ_TICK   = 1'b1
    } req_type_t;

    typedef struct packed
    {
        req_type_t           req_type;
        logic [SAMPLE_W-1:0] sample;
    } in_item_t;

    typedef struct packed
    {
        logic              report;
        logic [VOLT_W-1:0] voltage;
        logic              low_battery;
        logic              beep;
        logic [BEEP_W-1:0] beeps_done;
        logic              cutoff;
    } out_item_t;

endpackage

// File: sv/bvc_in_if.sv
// ----------------------------------------------------------------------------
// bvc_in_if: request channel
// Carries converter samples and alarm timer ticks with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bvc_in_if;
    logic             valid;
    logic             ready;
    bvc_pkg::in_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// File: sv/bvc_out_if.sv
// ----------------------------------------------------------------------------
// bvc_out_if: result channel
// Carries voltage reports and alarm results with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bvc_out_if;
    logic              valid;
    logic              ready;
    bvc_pkg::out_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// File: sv/battery_undervoltage_cutoff.sv
// ----------------------------------------------------------------------------
// battery_undervoltage_cutoff: averaged battery voltage monitor with alarm
// Sums converter samples in groups, reports the scaled voltage, arms a beep
// alarm at or below the threshold and latches cutoff after the last beep.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  req     | in  | valid/ready        | req_type, sample
//  rsp     | out | valid/ready        | report, voltage, low_battery, beep,
//          |     |                    | beeps_done, cutoff
//  apb     | in  | psel/penable/pready| threshold at byte address 0
//
//  one transfer per cycle sustained on req while rsp does not stall; every item
//  is held in the input register, and its result goes through the add, constant
//  multiply and threshold compare into the result register
//  rst_n clears the accumulator, alarm state, cutoff latch and both valid flags;
//  threshold resets to 1070
//  a stall on rsp holds the result register and fills the input register, then
//  drops req.ready; items that give no result still wait their turn
//
module battery_undervoltage_cutoff
(
    input  logic                         clk,
    input  logic                         rst_n,
    bvc_in_if.sink                       req,
    bvc_out_if.source                    rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bvc_pkg::PADDR_W-1:0]  paddr,
    input  logic [bvc_pkg::PDATA_W-1:0]  pwdata,
    output logic [bvc_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import bvc_pkg::*;

    // configuration
    logic [THRESHOLD_W-1:0] threshold_reg;

    // input stage
    logic     in_vld_reg;
    logic     in_vld_next;
    in_item_t in_item_reg;

    // block state
    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sum_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               armed_reg;
    logic               armed_next;
    logic [BEEP_W-1:0]  beep_cnt_reg;
    logic [BEEP_W-1:0]  beep_cnt_next;
    logic               cut_reg;
    logic               cut_next;

    // result stage
    logic      out_vld_reg;
    logic      out_vld_next;
    out_item_t out_item_reg;
    out_item_t res_item;
    logic      res_valid;

    // datapath
    logic               advance;
    logic               fire;
    logic               req_xfer;
    logic [SUM_W-1:0]   sum_add;
    logic [COUNT_W-1:0] count_add;
    logic               group_done;
    logic [PROD_W-1:0]  volt_prod;
    logic [VOLT_W-1:0]  volt;
    logic               volt_low;

    // ---------------------------------------------------------------- apb
    assign pready = 1'b1;

    always_comb
    begin
        prdata = '0;
        if (paddr == REG_THRESHOLD_ADDR)
        begin
            prdata = PDATA_W'(threshold_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr == REG_THRESHOLD_ADDR))
        begin
            threshold_reg <= pwdata[THRESHOLD_W-1:0];
        end
    end

    // ---------------------------------------------------------------- handshake
    // the pipeline moves whenever the result register is empty or being drained
    assign advance   = !out_vld_reg || rsp.ready;
    assign fire      = in_vld_reg && advance;
    assign req.ready = !in_vld_reg || advance;
    assign req_xfer  = req.valid && req.ready;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (req_xfer)
        begin
            in_vld_next = 1'b1;
        end
        else if (fire)
        begin
            in_vld_next = 1'b0;
        end
    end

    // ---------------------------------------------------------------- voltage
    assign sum_add    = sum_reg + SUM_W'(in_item_reg.sample);
    assign count_add  = count_reg + COUNT_W'(1);
    assign group_done = (count_add >= COUNT_W'(SAMPLES_PER_AVERAGE));

    // constant multiply by the scaled reciprocal, truncated by the shift
    assign volt_prod = PROD_W'(sum_add) * PROD_W'(VOLT_MUL);
    assign volt      = volt_prod[VOLT_SHIFT +: VOLT_W];
    assign volt_low  = (volt <= VOLT_W'(threshold_reg));

    // ---------------------------------------------------------------- item logic
    always_comb
    begin
        sum_next      = sum_reg;
        count_next    = count_reg;
        armed_next    = armed_reg;
        beep_cnt_next = beep_cnt_reg;
        cut_next      = cut_reg;
        res_valid     = 1'b0;
        res_item      = '0;

        // after cutoff every item is dropped without touching state
        if (fire && !cut_reg)
        begin
            case (in_item_reg.req_type)
                REQ_SAMPLE:
                begin
                    if (group_done)
                    begin
                        sum_next   = '0;
                        count_next = '0;
                        armed_next = volt_low;
                        if (!volt_low)
                        begin
                            beep_cnt_next = '0;
                        end
                        res_valid            = 1'b1;
                        res_item.report      = 1'b1;
                        res_item.voltage     = volt;
                        res_item.low_battery = volt_low;
                        res_item.beeps_done  = volt_low ? beep_cnt_reg : '0;
                    end
                    else
                    begin
                        sum_next   = sum_add;
                        count_next = count_add;
                    end
                end
                REQ_TICK:
                begin
                    // ticks only count while the alarm is armed
                    if (armed_reg)
                    begin
                        res_valid            = 1'b1;
                        res_item.low_battery = 1'b1;
                        if (beep_cnt_reg < BEEP_W'(BEEP_LIMIT))
                        begin
                            beep_cnt_next       = beep_cnt_reg + BEEP_W'(1);
                            res_item.beep       = 1'b1;
                            res_item.beeps_done = beep_cnt_reg + BEEP_W'(1);
                        end
                        else
                        begin
                            // last beep already given: open the relay
                            cut_next            = 1'b1;
                            res_item.cutoff     = 1'b1;
                            res_item.beeps_done = beep_cnt_reg;
                        end
                    end
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (fire)
        begin
            out_vld_next = res_valid;
        end
        else if (rsp.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
            sum_reg      <= '0;
            count_reg    <= '0;
            armed_reg    <= 1'b0;
            beep_cnt_reg <= '0;
            cut_reg      <= 1'b0;
        end
        else
        begin
            in_vld_reg   <= in_vld_next;
            out_vld_reg  <= out_vld_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            armed_reg    <= armed_next;
            beep_cnt_reg <= beep_cnt_next;
            cut_reg      <= cut_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            in_item_reg <= req.item;
        end
        if (fire && res_valid)
        begin
            out_item_reg <= res_item;
        end
    end

    assign rsp.valid = out_vld_reg;
    assign rsp.item  = out_item_reg;

    // ---------------------------------------------------------------- checks
`ifndef SYNTHESIS
    // cutoff is only given once the full beep count has been reached
    a_cutoff_after_beeps: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.item.cutoff) |-> (rsp.item.beeps_done == BEEP_W'(BEEP_LIMIT)))
        else $error("cutoff result before all beeps were given");

    // the cutoff latch never releases without a reset
    a_cut_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        cut_reg |=> cut_reg)
        else $error("cutoff latch cleared");

    // beep counter stays within the limit
    a_beep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        beep_cnt_reg <= BEEP_W'(BEEP_LIMIT))
        else $error("beep count above limit");

    // the sample counter restarts before reaching the group size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < COUNT_W'(SAMPLES_PER_AVERAGE))
        else $error("sample count reached group size");

    // a voltage report never carries alarm events
    a_report_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.item.report) |-> (!rsp.item.beep && !rsp.item.cutoff))
        else $error("report result carries beep or cutoff");
`endif

endmodule
